>>> rtl/onb_pkg.sv
package onb_pkg;

    // width of one axis component on the stream buses
    localparam int FIELD_W = 16;

    // control that travels beside the data through every stage
    typedef struct packed {
        logic valid;
        logic flag;     // a zero-length vector was met upstream
    } ctl_t;

endpackage

>>> rtl/onb_delay.sv
module onb_delay #(
    parameter int W     = 48,
    parameter int DEPTH = 20
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d_in,
    output logic [W-1:0] d_out
);
    logic [W-1:0] sr_reg [DEPTH];

    // advance the line only with the rest of the pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= d_in;
            for (int k = 1; k < DEPTH; k++) begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign d_out = sr_reg[DEPTH-1];

endmodule

>>> rtl/onb_norm.sv
module onb_norm #(
    parameter int FRAC_BITS = 14,
    parameter int IW        = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  onb_pkg::ctl_t               ctl_in,
    input  logic signed [IW-1:0]        v_in  [3],
    output onb_pkg::ctl_t               ctl_out,
    output logic signed [FRAC_BITS+1:0] r_out [3]
);
    import onb_pkg::*;

    localparam int MW  = FRAC_BITS + 1;
    localparam int SQW = 2 * IW;
    localparam int CW  = 2 * FRAC_BITS + 2 * IW + 6;
    localparam int NS  = FRAC_BITS + 1;
    localparam logic [MW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    ctl_t               a_ctl_reg;
    logic [IW-1:0]      a_mag_reg [3];
    logic               a_neg_reg [3];
    ctl_t               b_ctl_reg;
    logic [SQW-1:0]     b_sq_reg  [3];
    logic               b_neg_reg [3];
    logic [SQW+1:0]     len_next;

    // search state: stage j decides result bit FRAC_BITS-j
    ctl_t               s_ctl_reg [NS+1];
    logic signed [CW-1:0] s_l_reg [NS+1];
    logic signed [CW-1:0] s_q_reg [NS+1][3];   // (2m-1)^2 * len
    logic signed [CW-1:0] s_r_reg [NS+1][3];   // (2m-1) * len
    logic signed [CW-1:0] s_rhs_reg [NS+1][3]; // 4 * a^2 * 2^(2F)
    logic [MW-1:0]      s_m_reg   [NS+1][3];
    logic               s_neg_reg [NS+1][3];

    assign len_next = {2'b00, b_sq_reg[0]} + {2'b00, b_sq_reg[1]} + {2'b00, b_sq_reg[2]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctl_reg    <= '0;
            b_ctl_reg    <= '0;
            s_ctl_reg[0] <= '0;
        end else if (en) begin
            a_ctl_reg    <= ctl_in;
            b_ctl_reg    <= a_ctl_reg;
            s_ctl_reg[0] <= '{valid: b_ctl_reg.valid, flag: b_ctl_reg.flag || (len_next == '0)};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_mag_reg[i] <= v_in[i][IW-1] ? IW'(-v_in[i]) : IW'(v_in[i]);
                a_neg_reg[i] <= v_in[i][IW-1];
                b_sq_reg[i]  <= SQW'(a_mag_reg[i]) * SQW'(a_mag_reg[i]);
                b_neg_reg[i] <= a_neg_reg[i];
                s_q_reg[0][i]   <= CW'(len_next);
                s_r_reg[0][i]   <= -$signed(CW'(len_next));
                s_rhs_reg[0][i] <= $signed(CW'(b_sq_reg[i]) << (2 * FRAC_BITS + 2));
                s_m_reg[0][i]   <= '0;
                s_neg_reg[0][i] <= b_neg_reg[i];
            end
            s_l_reg[0] <= CW'(len_next);
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_bit
        localparam int K = FRAC_BITS - j;
        logic signed [CW-1:0] q_next [3];
        logic signed [CW-1:0] r_next [3];
        logic                 take   [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                q_next[i] = s_q_reg[j][i] + (s_r_reg[j][i] <<< (K + 2))
                          + (s_l_reg[j] <<< (2 * K + 2));
                r_next[i] = s_r_reg[j][i] + (s_l_reg[j] <<< (K + 1));
                take[i]   = !s_m_reg[j][i][FRAC_BITS] && (q_next[i] <= s_rhs_reg[j][i]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_ctl_reg[j+1] <= '0;
            end else if (en) begin
                s_ctl_reg[j+1] <= s_ctl_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_l_reg[j+1] <= s_l_reg[j];
                for (int i = 0; i < 3; i++) begin
                    s_rhs_reg[j+1][i] <= s_rhs_reg[j][i];
                    s_neg_reg[j+1][i] <= s_neg_reg[j][i];
                    if (take[i]) begin
                        s_m_reg[j+1][i] <= s_m_reg[j][i] | (MW'(1) << K);
                        s_q_reg[j+1][i] <= q_next[i];
                        s_r_reg[j+1][i] <= r_next[i];
                    end else begin
                        s_m_reg[j+1][i] <= s_m_reg[j][i];
                        s_q_reg[j+1][i] <= s_q_reg[j][i];
                        s_r_reg[j+1][i] <= s_r_reg[j][i];
                    end
                end
            end
        end
    end

    assign ctl_out = s_ctl_reg[NS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r_out[i] = s_neg_reg[NS][i] ? -$signed({1'b0, s_m_reg[NS][i]})
                                        :  $signed({1'b0, s_m_reg[NS][i]});
        end
    end

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ctl_reg[NS].valid |-> (s_m_reg[NS][0] <= ONE) && (s_m_reg[NS][1] <= ONE)
                                && (s_m_reg[NS][2] <= ONE))
        else $error("normalized magnitude above one");

endmodule

>>> rtl/onb_cross.sv
module onb_cross #(
    parameter int FRAC_BITS = 14
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  onb_pkg::ctl_t               ctl_in,
    input  logic signed [FRAC_BITS+1:0] a_in [3],
    input  logic signed [FRAC_BITS+1:0] b_in [3],
    output onb_pkg::ctl_t               ctl_out,
    output logic signed [FRAC_BITS+2:0] c_out [3]
);
    import onb_pkg::*;

    localparam int SW = FRAC_BITS + 2;
    localparam int PW = 2 * SW;
    localparam int OW = FRAC_BITS + 3;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);

    ctl_t                 p_ctl_reg;
    logic signed [PW-1:0] p_reg [6];
    ctl_t                 c_ctl_reg;
    logic signed [OW-1:0] c_reg [3];
    logic signed [PW:0]   diff_next [3];
    logic [PW:0]          mag_next  [3];
    logic [PW:0]          rnd_next  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_ctl_reg <= '0;
            c_ctl_reg <= '0;
        end else if (en) begin
            p_ctl_reg <= ctl_in;
            c_ctl_reg <= p_ctl_reg;
        end
    end

    // round half away from zero, then drop the fraction scale
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff_next[i] = (PW+1)'(p_reg[2*i]) - (PW+1)'(p_reg[2*i+1]);
            mag_next[i]  = diff_next[i][PW] ? (PW+1)'(-diff_next[i]) : (PW+1)'(diff_next[i]);
            rnd_next[i]  = (mag_next[i] + HALF) >> FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= PW'(a_in[1]) * PW'(b_in[2]);
            p_reg[1] <= PW'(a_in[2]) * PW'(b_in[1]);
            p_reg[2] <= PW'(a_in[2]) * PW'(b_in[0]);
            p_reg[3] <= PW'(a_in[0]) * PW'(b_in[2]);
            p_reg[4] <= PW'(a_in[0]) * PW'(b_in[1]);
            p_reg[5] <= PW'(a_in[1]) * PW'(b_in[0]);
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= diff_next[i][PW] ? -$signed(OW'(rnd_next[i]))
                                             :  $signed(OW'(rnd_next[i]));
            end
        end
    end

    assign ctl_out = c_ctl_reg;
    assign c_out   = c_reg;

endmodule

>>> rtl/orthonormalize_basis_3d_unit.sv
// Channel  Dir  tdata                                  tuser
// s_       in   96 bits: X axis x,y,z then Y axis x,y,z  -
// m_       out  144 bits: X, Y, Z axes (x,y,z each)      degenerate
//
// One basis enters per cycle while the output word is not held; the pipeline holds
// about 4*FRAC_BITS+23 items. Each word passes in series through four of the five
// normalizers (one bit of each normalized component per stage) and three
// cross-product units, then the output register.
// Reset clears all valid bits; payload registers are left as they are.
// A held output word freezes every stage, so nothing is lost or repeated.
module orthonormalize_basis_3d_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // x_axis_x, x_axis_y, x_axis_z, y_axis_x, y_axis_y, y_axis_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // out_x_x, out_x_y, out_x_z, out_y_x, out_y_y, out_y_z,
                                    // out_z_x, out_z_y, out_z_z
    output logic [0:0]   m_tuser    // degenerate
);
    import onb_pkg::*;

    localparam int SW = FRAC_BITS + 2;     // unit vector component
    localparam int CW = FRAC_BITS + 3;     // rounded cross product component
    localparam int NL = FRAC_BITS + 4;     // normalizer latency
    localparam int DL = NL + 2;            // cross plus normalizer
    localparam int VW = 3 * SW;

    logic en;
    ctl_t in_ctl;
    logic signed [FIELD_W-1:0] xi [3];
    logic signed [FIELD_W-1:0] yi [3];

    ctl_t nx_ctl, ny_ctl, k1_ctl, nz_ctl, k2_ctl, nx2_ctl, k3_ctl, ny2_ctl;
    logic signed [SW-1:0] xa [3], ya [3], za [3], xb [3], yb [3];
    logic signed [SW-1:0] ya_d [3], za_d [3], za_dd [3], xb_d [3];
    logic signed [CW-1:0] zc [3], xc [3], yc [3];
    logic [VW-1:0] ya_p, ya_dp, za_p, za_dp, za_ddp, xb_p, xb_dp;

    logic               m_valid_reg;
    logic [143:0]       m_data_reg;
    logic               m_deg_reg;
    logic [143:0]       m_data_next;

    // advance everything unless the output word is waiting
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign in_ctl   = '{valid: s_tvalid, flag: 1'b0};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xi[i] = $signed(s_tdata[FIELD_W*i +: FIELD_W]);
            yi[i] = $signed(s_tdata[FIELD_W*(3+i) +: FIELD_W]);
        end
    end

    onb_norm #(.FRAC_BITS(FRAC_BITS), .IW(FIELD_W)) u_norm_x (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(in_ctl), .v_in(xi), .ctl_out(nx_ctl), .r_out(xa));

    onb_norm #(.FRAC_BITS(FRAC_BITS), .IW(FIELD_W)) u_norm_y (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(in_ctl), .v_in(yi), .ctl_out(ny_ctl), .r_out(ya));

    // Z = norm(X x Y); either degenerate input flags the word
    onb_cross #(.FRAC_BITS(FRAC_BITS)) u_cross_z (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in('{valid: nx_ctl.valid, flag: nx_ctl.flag || ny_ctl.flag}),
        .a_in(xa), .b_in(ya), .ctl_out(k1_ctl), .c_out(zc));

    onb_norm #(.FRAC_BITS(FRAC_BITS), .IW(CW)) u_norm_z (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(k1_ctl), .v_in(zc), .ctl_out(nz_ctl), .r_out(za));

    // pack vectors for the alignment lines
    assign ya_p = {ya[2], ya[1], ya[0]};
    assign za_p = {za[2], za[1], za[0]};
    assign xb_p = {xb[2], xb[1], xb[0]};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ya_d[i]  = $signed(ya_dp[SW*i +: SW]);
            za_d[i]  = $signed(za_dp[SW*i +: SW]);
            za_dd[i] = $signed(za_ddp[SW*i +: SW]);
            xb_d[i]  = $signed(xb_dp[SW*i +: SW]);
        end
    end

    onb_delay #(.W(VW), .DEPTH(DL)) u_dly_y (
        .aclk(aclk), .en(en), .d_in(ya_p), .d_out(ya_dp));

    // X = norm(Y x Z)
    onb_cross #(.FRAC_BITS(FRAC_BITS)) u_cross_x (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(nz_ctl), .a_in(ya_d), .b_in(za), .ctl_out(k2_ctl), .c_out(xc));

    onb_norm #(.FRAC_BITS(FRAC_BITS), .IW(CW)) u_norm_x2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(k2_ctl), .v_in(xc), .ctl_out(nx2_ctl), .r_out(xb));

    onb_delay #(.W(VW), .DEPTH(DL)) u_dly_z (
        .aclk(aclk), .en(en), .d_in(za_p), .d_out(za_dp));

    // Y = norm(Z x X)
    onb_cross #(.FRAC_BITS(FRAC_BITS)) u_cross_y (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(nx2_ctl), .a_in(za_d), .b_in(xb), .ctl_out(k3_ctl), .c_out(yc));

    onb_norm #(.FRAC_BITS(FRAC_BITS), .IW(CW)) u_norm_y2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(k3_ctl), .v_in(yc), .ctl_out(ny2_ctl), .r_out(yb));

    // hold X and Z until the final Y arrives
    onb_delay #(.W(VW), .DEPTH(DL)) u_dly_x_out (
        .aclk(aclk), .en(en), .d_in(xb_p), .d_out(xb_dp));

    onb_delay #(.W(VW), .DEPTH(DL)) u_dly_z_out (
        .aclk(aclk), .en(en), .d_in(za_dp), .d_out(za_ddp));

    // keep the low field bits; drop everything on a degenerate word
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_data_next[FIELD_W*i +: FIELD_W]     = FIELD_W'(xb_d[i]);
            m_data_next[FIELD_W*(3+i) +: FIELD_W] = FIELD_W'(yb[i]);
            m_data_next[FIELD_W*(6+i) +: FIELD_W] = FIELD_W'(za_dd[i]);
        end
        if (ny2_ctl.flag) begin
            m_data_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ny2_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
            m_deg_reg  <= ny2_ctl.flag;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_deg_reg;

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate word carries nonzero axes");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a blocked output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule
